// ===== hw/rtl/bezier_path_animator_macros.svh =====
// ----------------------------------------------------------------------------
// Bezier path animator assertion macros
// Short forms for the concurrent checks of the path animator.
// ----------------------------------------------------------------------------
`ifndef BEZIER_PATH_ANIMATOR_MACROS_SVH
`define BEZIER_PATH_ANIMATOR_MACROS_SVH

// Check on every rising edge outside of reset.
`define BPA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check on every rising edge, reset included.
`define BPA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bezier path animator package
// Widths, register indexes, defaults and the divider request type.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

	localparam int DEF_COORD_BITS  = 21;
	localparam int DEF_T_FRAC_BITS = 16;

	localparam int TIME_BITS    = 32;
	localparam int SPAN_BITS    = 24;
	localparam int CFG_BITS     = 63;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_POINT0 = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_POINT1 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_POINT2 = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_POINT3 = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPAN   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOOP   = 3'd5;

	localparam logic [SPAN_BITS-1:0] SPAN_RESET = 24'd1000;

	typedef struct packed {
		logic                 start;
		logic [SPAN_BITS-1:0] dividend;
		logic [SPAN_BITS-1:0] divisor;
	} div_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpa_div.sv =====
// ----------------------------------------------------------------------------
// Bezier path animator divider
// Restoring divider that forms elapsed * 2^FRAC_BITS / span, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_div
	import bpa_pkg::*;
#(
	parameter int FRAC_BITS = DEF_T_FRAC_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_req_t         req,
	output logic                  done,
	output logic [FRAC_BITS:0]    quot
);

	localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [SPAN_BITS-1:0]  rem_q;
	logic [SPAN_BITS-1:0]  div_q;
	logic [FRAC_BITS-1:0]  q_q;
	logic                  full_q;
	logic [SPAN_BITS:0]    shl_w;
	logic [SPAN_BITS:0]    diff_w;
	logic                  fit_w;

	assign shl_w  = {rem_q, 1'b0};
	assign diff_w = shl_w - {1'b0, div_q};
	assign fit_w  = shl_w >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			div_q  <= req.divisor;
			q_q    <= '0;
			full_q <= req.dividend == req.divisor;
		end else if (busy_q) begin
			rem_q <= fit_w ? diff_w[SPAN_BITS-1:0] : shl_w[SPAN_BITS-1:0];
			q_q   <= {q_q[FRAC_BITS-2:0], fit_w};
		end
	end

	assign done = done_q;
	assign quot = full_q ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, q_q};

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_mul.sv =====
// ----------------------------------------------------------------------------
// Bezier path animator multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_mul
	import bpa_pkg::*;
#(
	parameter int A_BITS = DEF_T_FRAC_BITS + 3,
	parameter int B_BITS = DEF_COORD_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic signed [A_BITS-1:0]   a,
	input  wire logic signed [B_BITS-1:0]   b,
	output logic signed [A_BITS+B_BITS-1:0] p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bezier_path_animator.sv =====
// ----------------------------------------------------------------------------
// Bezier path animator
// Turns tick times into a position on a cubic Bezier path in three axes.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    now_ms, start_ms, paused_ms
//  output    out_valid / out_ready  pos_x, pos_y, pos_z, moved, finished,
//                                   restarted, halted
//  config    cfg_we                 cfg_index, cfg_data
//
// A moving tick passes through the restoring divider, then 18 slots on the
// shared multiplier, then the done state, which raises out_valid. A tick after
// the end raises out_valid in the cycle after its accept. in_ready is low
// while a tick is in work and while a beat waits unaccepted. Reset clears
// control state and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_path_animator
	import bpa_pkg::*;
#(
	parameter int COORD_BITS  = DEF_COORD_BITS,
	parameter int T_FRAC_BITS = DEF_T_FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  wire logic [CFG_BITS-1:0]          cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [TIME_BITS-1:0]         now_ms,
	input  wire logic [TIME_BITS-1:0]         start_ms,
	input  wire logic [TIME_BITS-1:0]         paused_ms,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [COORD_BITS-1:0]      pos_x,
	output logic signed [COORD_BITS-1:0]      pos_y,
	output logic signed [COORD_BITS-1:0]      pos_z,
	output logic                              moved,
	output logic                              finished,
	output logic                              restarted,
	output logic                              halted
);

	localparam int ONE_W = T_FRAC_BITS + 1;
	localparam int WW    = T_FRAC_BITS + 2;
	localparam int WA    = T_FRAC_BITS + 3;
	localparam int WB    = (T_FRAC_BITS + 2 > COORD_BITS) ? T_FRAC_BITS + 2 : COORD_BITS;
	localparam int WP    = WA + WB;
	localparam int WACC  = WP + 2;

	localparam logic [ONE_W-1:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
	localparam logic signed [WACC-1:0] SAT_HI = WACC'((2 ** (COORD_BITS - 1)) - 1);
	localparam logic signed [WACC-1:0] SAT_LO = -SAT_HI - WACC'(1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [4:0] STEP_UU     = 5'd0;
	localparam logic [4:0] STEP_TT     = 5'd1;
	localparam logic [4:0] STEP_B0     = 5'd2;
	localparam logic [4:0] STEP_B1     = 5'd3;
	localparam logic [4:0] STEP_B2     = 5'd4;
	localparam logic [4:0] STEP_B3     = 5'd5;
	localparam logic [4:0] STEP_BLEND  = 5'd6;
	localparam logic [4:0] STEP_LAST   = 5'd17;

	localparam logic [1:0] TERM_LAST = 2'd3;
	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;

	logic [CFG_BITS-1:0]  pt_q [4];
	logic [SPAN_BITS-1:0] span_q;
	logic                 loop_q;

	logic [1:0]           state_q;
	logic [4:0]           st_q;
	logic [4:0]           tag_s1;
	logic                 tag_vld_s1;
	logic                 out_valid_q;
	logic                 moved_q;
	logic                 restarted_q;
	logic                 ended_q;
	logic                 halted_q;

	logic [ONE_W-1:0]     t_q;
	logic [ONE_W-1:0]     u_q;
	logic [ONE_W-1:0]     uu_q;
	logic [ONE_W-1:0]     tt_q;
	logic [WW-1:0]        w_q [4];
	logic signed [WACC-1:0] acc_q;
	logic signed [COORD_BITS-1:0] held_x_q;
	logic signed [COORD_BITS-1:0] held_y_q;
	logic signed [COORD_BITS-1:0] held_z_q;

	logic [TIME_BITS+1:0] el_w;
	logic [TIME_BITS-1:0] elapsed_w;
	logic [SPAN_BITS-1:0] span_w;
	logic                 over_w;
	logic                 accept_w;
	div_req_t             div_req;
	logic                 div_done;
	logic [ONE_W-1:0]     div_quot;

	logic                 mul_en;
	logic signed [WA-1:0] mul_a;
	logic signed [WB-1:0] mul_b;
	logic signed [WP-1:0] mul_p;

	logic [4:0]           iss_idx_w;
	logic signed [COORD_BITS-1:0] iss_crd_w;

	logic [4:0]           cons_idx_w;
	logic [1:0]           cons_term_w;
	logic [1:0]           cons_axis_w;
	logic [ONE_W-1:0]     pw_w;
	logic signed [WACC-1:0] sum_w;
	logic signed [WACC-1:0] sh_w;
	logic signed [COORD_BITS-1:0] sat_w;
	logic                 store_w;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				pt_q[i] <= '0;
			end
			span_q <= SPAN_RESET;
			loop_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POINT0: pt_q[0] <= cfg_data;
				REG_POINT1: pt_q[1] <= cfg_data;
				REG_POINT2: pt_q[2] <= cfg_data;
				REG_POINT3: pt_q[3] <= cfg_data;
				REG_SPAN:   span_q  <= cfg_data[SPAN_BITS-1:0];
				REG_LOOP:   loop_q  <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	assign el_w      = {2'b00, now_ms} - {2'b00, start_ms} - {2'b00, paused_ms};
	assign elapsed_w = el_w[TIME_BITS+1] ? '0 : el_w[TIME_BITS-1:0];
	assign span_w    = (span_q == '0) ? SPAN_BITS'(1) : span_q;
	assign over_w    = elapsed_w > TIME_BITS'(span_w);

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept_w = in_valid && in_ready;

	assign div_req.start    = accept_w && !ended_q;
	assign div_req.dividend = over_w ? span_w : elapsed_w[SPAN_BITS-1:0];
	assign div_req.divisor  = span_w;

	bpa_div #(
		.FRAC_BITS(T_FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			st_q        <= '0;
			tag_s1      <= '0;
			tag_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			moved_q     <= 1'b0;
			restarted_q <= 1'b0;
			ended_q     <= 1'b0;
			halted_q    <= 1'b0;
		end else begin
			tag_s1     <= st_q;
			tag_vld_s1 <= state_q == ST_MUL;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_w) begin
						if (ended_q && loop_q) begin
							ended_q     <= 1'b0;
							halted_q    <= 1'b0;
							out_valid_q <= 1'b1;
							moved_q     <= 1'b0;
							restarted_q <= 1'b1;
						end else if (ended_q) begin
							halted_q    <= 1'b1;
							out_valid_q <= 1'b1;
							moved_q     <= 1'b0;
							restarted_q <= 1'b0;
						end else begin
							ended_q <= over_w;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						st_q    <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					st_q <= st_q + 1'b1;
					if (st_q == STEP_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					out_valid_q <= 1'b1;
					moved_q     <= 1'b1;
					restarted_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Operand selection for the shared multiplier.
	assign iss_idx_w = st_q - STEP_BLEND;
	assign iss_crd_w = pt_q[iss_idx_w[1:0]][iss_idx_w[3:2]*COORD_BITS +: COORD_BITS];
	assign mul_en    = state_q == ST_MUL;

	always_comb begin
		unique case (st_q)
			STEP_UU: begin
				mul_a = WA'(u_q);
				mul_b = WB'(u_q);
			end
			STEP_TT: begin
				mul_a = WA'(t_q);
				mul_b = WB'(t_q);
			end
			STEP_B0: begin
				mul_a = WA'(uu_q);
				mul_b = WB'(u_q);
			end
			STEP_B1: begin
				mul_a = WA'(uu_q);
				mul_b = WB'(t_q);
			end
			STEP_B2: begin
				mul_a = WA'(tt_q);
				mul_b = WB'(u_q);
			end
			STEP_B3: begin
				mul_a = WA'(tt_q);
				mul_b = WB'(t_q);
			end
			default: begin
				mul_a = WA'(w_q[iss_idx_w[1:0]]);
				mul_b = WB'(iss_crd_w);
			end
		endcase
	end

	bpa_mul #(
		.A_BITS(WA),
		.B_BITS(WB)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	// Product handling, in the cycle after the issue.
	assign cons_idx_w  = tag_s1 - STEP_BLEND;
	assign cons_term_w = cons_idx_w[1:0];
	assign cons_axis_w = cons_idx_w[3:2];
	assign pw_w        = mul_p[T_FRAC_BITS +: ONE_W];
	assign sum_w       = ((cons_term_w == 2'd0) ? '0 : acc_q) + WACC'(mul_p);
	assign sh_w        = sum_w >>> T_FRAC_BITS;
	assign sat_w       = (sh_w > SAT_HI) ? SAT_HI[COORD_BITS-1:0] :
	                     (sh_w < SAT_LO) ? SAT_LO[COORD_BITS-1:0] :
	                     sh_w[COORD_BITS-1:0];
	assign store_w     = tag_vld_s1 && (tag_s1 >= STEP_BLEND) && (cons_term_w == TERM_LAST);

	always_ff @(posedge clk) begin
		if (div_done) begin
			t_q <= div_quot;
			u_q <= ONE - div_quot;
		end
		if (tag_vld_s1) begin
			unique case (tag_s1)
				STEP_UU: uu_q   <= pw_w;
				STEP_TT: tt_q   <= pw_w;
				STEP_B0: w_q[0] <= WW'(pw_w);
				STEP_B1: w_q[1] <= (WW'(pw_w) << 1) + WW'(pw_w);
				STEP_B2: w_q[2] <= (WW'(pw_w) << 1) + WW'(pw_w);
				STEP_B3: w_q[3] <= WW'(pw_w);
				default: acc_q  <= sum_w;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q <= '0;
			held_y_q <= '0;
			held_z_q <= '0;
		end else if (store_w) begin
			unique case (cons_axis_w)
				AXIS_X:  held_x_q <= sat_w;
				AXIS_Y:  held_y_q <= sat_w;
				default: held_z_q <= sat_w;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = held_x_q;
	assign pos_y     = held_y_q;
	assign pos_z     = held_z_q;
	assign moved     = moved_q;
	assign finished  = ended_q;
	assign restarted = restarted_q;
	assign halted    = halted_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// Bezier path animator checker
// Port-level checks on beats and status flags, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bezier_path_animator_macros.svh"

module bpa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic moved,
	input wire logic finished,
	input wire logic restarted,
	input wire logic halted
);

	`BPA_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "output beat dropped")
	`BPA_ASSERT_ALWAYS(a_no_overrun, clk, in_ready |-> (!out_valid || out_ready), "input taken over a waiting beat")
	`BPA_ASSERT(a_restart_flags, clk, arst_n, out_valid && restarted |-> !moved && !finished && !halted, "restart beat carries stale flags")
	`BPA_ASSERT(a_halt_ended, clk, arst_n, out_valid && halted |-> finished && !moved, "halted without end")
	`BPA_ASSERT(a_accept_quiet, clk, arst_n, in_valid && in_ready |=> !in_ready || out_valid, "second input accepted while busy")

endmodule

bind bezier_path_animator bpa_checker u_bpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.moved     (moved),
	.finished  (finished),
	.restarted (restarted),
	.halted    (halted)
);

`default_nettype wire
